>>> rtl/core/base64_stream_decoder_core_defines.svh
// Assertion macros shared by the Base64 stream decoder RTL.
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define B64D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define B64D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/b64d_pkg.sv
// Types, constants and character decode functions for the Base64 stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package b64d_pkg;

  // Report status codes
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StShort   = 2'd2
  } status_e;

  localparam logic [7:0] PadCode  = 8'h3D;
  localparam logic [7:0] PlusCode = 8'h2B;
  localparam logic [7:0] SlashCode = 8'h2F;
  localparam int unsigned GroupSize = 4;

  // Job queue between front and back
  localparam int unsigned JobQDepth = 4;
  localparam int unsigned JobQPtrW  = 2;

  // One closed group or end of text, as handed to the result sequencer
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      num_bytes;
    logic            report;
    status_e         status;
    logic [15:0]     total;
  } job_t;

  // True for A-Z, a-z, 0-9, '+' and '/'
  function automatic logic b64_valid(input logic [7:0] c);
    b64_valid = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h30 && c <= 8'h39) || (c == PlusCode) || (c == SlashCode);
  endfunction

  // Six-bit value of a Base64 character; zero for anything else
  function automatic logic [5:0] b64_sextet(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
    else if (c == PlusCode) v = 8'd62;
    else if (c == SlashCode) v = 8'd63;
    b64_sextet = v[5:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/b64d_front.sv
// Front end: takes characters, holds the open group, closes groups and builds jobs.
`timescale 1ns / 1ps
`default_nettype none
module b64d_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     char_code_i,
  input  wire logic           has_char_i,
  input  wire logic           end_of_text_i,
  output logic                job_push_o,
  output b64d_pkg::job_t      job_o
);
  import b64d_pkg::*;

  localparam int WideW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [7:0]             held_q [3];
  logic [1:0]             grp_cnt_q, grp_cnt_d;
  status_e                err_q, err_d;
  logic [COUNT_WIDTH-1:0] byte_cnt_q, byte_cnt_d;

  logic                   has_eff, close4, do_close, short_grp, bad_char;
  logic [2:0]             grp_len, strip_len;
  logic [7:0]             g [GroupSize];
  logic [5:0]             s [GroupSize];
  logic [1:0]             nb;
  status_e                err_new;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [WideW-1:0]       cnt_wide;
  logic [15:0]            total;

  // Group assembly: held characters first, the new one after them
  always_comb begin
    has_eff  = has_char_i && (err_q == StOk);
    close4   = has_eff && (grp_cnt_q == 2'd3);
    grp_len  = close4 ? 3'd4 : ({1'b0, grp_cnt_q} + {2'b0, has_eff});
    do_close = (err_q == StOk) && (close4 || (end_of_text_i && (grp_len != 3'd0)));
    for (int i = 0; i < 3; i++) begin
      g[i] = (2'(i) < grp_cnt_q) ? held_q[i] : char_code_i;
    end
    g[3] = char_code_i;
    for (int i = 0; i < GroupSize; i++) begin
      s[i] = b64_sextet(g[i]);
    end
  end

  // Strip trailing padding, then check length and characters
  always_comb begin
    strip_len = grp_len;
    for (int i = GroupSize - 1; i >= 0; i--) begin
      if ((strip_len == 3'(i + 1)) && (g[i] == PadCode)) strip_len = 3'(i);
    end
    short_grp = (strip_len < 3'd2);
    bad_char  = 1'b0;
    for (int i = 0; i < GroupSize; i++) begin
      if ((3'(i) < strip_len) && !b64_valid(g[i])) bad_char = 1'b1;
    end
    nb = (do_close && !short_grp && !bad_char) ? 2'(strip_len - 3'd1) : 2'd0;
    if (!do_close) err_new = err_q;
    else if (short_grp) err_new = StShort;
    else if (bad_char) err_new = StInvalid;
    else err_new = StOk;
  end

  // Saturating byte count and the 16-bit reported total
  always_comb begin
    sum      = {1'b0, byte_cnt_q} + (COUNT_WIDTH + 1)'(nb);
    cnt_new  = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    cnt_wide = WideW'(cnt_new);
    total    = (cnt_wide > WideW'(16'hFFFF)) ? 16'hFFFF : cnt_wide[15:0];
  end

  // Job towards the back end
  always_comb begin
    job_o.data      = {s[2][1:0], s[3], s[1][3:0], s[2][5:2], s[0], s[1][5:4]};
    job_o.num_bytes = nb;
    job_o.report    = end_of_text_i;
    job_o.status    = err_new;
    job_o.total     = total;
    job_push_o      = accept_i && ((nb != 2'd0) || end_of_text_i);
  end

  // Next state; end of text starts a fresh one
  always_comb begin
    grp_cnt_d  = grp_cnt_q;
    err_d      = err_q;
    byte_cnt_d = byte_cnt_q;
    if (accept_i) begin
      if (end_of_text_i) begin
        grp_cnt_d  = 2'd0;
        err_d      = StOk;
        byte_cnt_d = '0;
      end else begin
        if (has_eff) grp_cnt_d = close4 ? 2'd0 : grp_cnt_q + 2'd1;
        err_d      = err_new;
        byte_cnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_cnt_q  <= 2'd0;
      err_q      <= StOk;
      byte_cnt_q <= '0;
    end else begin
      grp_cnt_q  <= grp_cnt_d;
      err_q      <= err_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

  // Held characters: payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept_i && has_eff && (grp_cnt_q != 2'd3)) begin
      held_q[grp_cnt_q] <= char_code_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/b64d_queue.sv
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module b64d_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire b64d_pkg::job_t push_job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output b64d_pkg::job_t      head_o,
  output logic                empty_o
);
  import b64d_pkg::*;

  job_t                mem_q [JobQDepth];
  logic [JobQPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [JobQPtrW:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (JobQPtrW + 1)'(JobQDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Entries: payload, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

endmodule
`default_nettype wire

>>> rtl/core/b64d_back.sv
// Back end: walks the head job and presents its bytes and report one beat at a time.
`timescale 1ns / 1ps
`default_nettype none
module b64d_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire b64d_pkg::job_t head_i,
  input  wire logic           head_empty_i,
  output logic                release_o,
  input  wire logic           pop_i,
  output logic                kind_o,
  output logic [7:0]          data_byte_o,
  output logic [1:0]          status_o,
  output logic [15:0]         total_bytes_o,
  output logic                last_of_run_o
);
  import b64d_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       is_byte, take;

  // Byte beats first, then the report if the job has one
  always_comb begin
    is_byte = (idx_q < head_i.num_bytes);
    if (is_byte) begin
      kind_o        = 1'b0;
      data_byte_o   = head_i.data[idx_q];
      status_o      = StOk;
      total_bytes_o = 16'd0;
      last_of_run_o = (idx_q == head_i.num_bytes - 2'd1) && !head_i.report;
    end else begin
      kind_o        = 1'b1;
      data_byte_o   = 8'd0;
      status_o      = head_i.status;
      total_bytes_o = head_i.total;
      last_of_run_o = 1'b1;
    end
  end

  assign take      = pop_i && !head_empty_i;
  assign release_o = take && last_of_run_o;

  always_comb begin
    idx_d = idx_q;
    if (release_o) idx_d = 2'd0;
    else if (take) idx_d = idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/base64_stream_decoder_core.sv
// Base64 stream decoder: top level joining front end, job queue and result sequencer.
//
// Usage
//   Input channel: one beat per character (char_code_i, has_char_i, end_of_text_i),
//   taken at a clock edge with push high and full low. A beat with end_of_text_i
//   set closes any partial group and asks for the end-of-text report.
//   Result channel: queue-like; while empty is low the oldest result sits on the
//   result ports and is taken at an edge with pop high. Data bytes come with
//   kind_o low, the report with kind_o high; last_of_run_o marks the final result
//   caused by one input beat.
//   Each result's job is registered in the job queue and shown once older jobs drain.
//   Throughput: one input beat per cycle while the four-entry job queue has room;
//   the result port moves one beat per cycle while pop is high, and an input beat
//   can cause up to four results, which hold the output until all are taken.
//   Receiver stall: jobs gather in the queue; full rises when it holds four and
//   input is held off until a job drains. Nothing is dropped.
//   Reset: clears the open group, error status, byte count and queue; the first
//   beat after reset starts a new text.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_decoder_core_defines.svh"
module base64_stream_decoder_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        has_char_i,
  input  wire logic        end_of_text_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             kind_o,
  output logic [7:0]       data_byte_o,
  output logic [1:0]       status_o,
  output logic [15:0]      total_bytes_o,
  output logic             last_of_run_o
);
  import b64d_pkg::*;

  logic accept, job_push, job_release;
  job_t job, head;

  assign accept = push && !full;

  b64d_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .char_code_i  (char_code_i),
    .has_char_i   (has_char_i),
    .end_of_text_i(end_of_text_i),
    .job_push_o   (job_push),
    .job_o        (job)
  );

  b64d_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (job_push),
    .push_job_i(job),
    .full_o    (full),
    .pop_i     (job_release),
    .head_o    (head),
    .empty_o   (empty)
  );

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (empty),
    .release_o    (job_release),
    .pop_i        (pop),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .status_o     (status_o),
    .total_bytes_o(total_bytes_o),
    .last_of_run_o(last_of_run_o)
  );

  // Checks on the result sequencing
  `B64D_ASSERT_IMP(a_report_is_last, !empty && kind_o, last_of_run_o, "report not last of run")
  `B64D_ASSERT_IMP(a_byte_fields_clear, !empty && !kind_o, (status_o == StOk) && (total_bytes_o == 16'd0), "data beat carries report fields")
  `B64D_ASSERT_IMP(a_full_not_empty, full, !empty, "queue full and empty together")
  `B64D_ASSERT_NXT(a_push_fills, job_push && !full, !empty, "queued job not visible")

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the Base64 stream decoder core.
`timescale 1ns / 1ps
module tb;
  import b64d_pkg::*;

  localparam int GAP_MAX     = 8;
  localparam int HOLD_AT     = 14;
  localparam int HOLD_LEN    = 200;
  localparam int TAIL_CYCLES = 16;
  localparam int RAND_BEATS  = 75;

  // How a generated text is closed
  localparam int EndNone   = 0;
  localparam int EndOnLast = 1;
  localparam int EndBare   = 2;

  typedef enum logic [1:0] {RxFree, RxCoin, RxSlow} rx_mode_e;

  typedef struct packed {
    logic [7:0] code;
    logic       has;
    logic       eot;
    logic       drain;
  } beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    status_e     status;
    logic [15:0] total;
    logic        last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_code_i = 8'h00;
  logic        has_char_i = 1'b0;
  logic        end_of_text_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind_o;
  logic [7:0]  data_byte_o;
  logic [1:0]  status_o;
  logic [15:0] total_bytes_o;
  logic        last_of_run_o;

  base64_stream_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_code_i   (char_code_i),
    .has_char_i    (has_char_i),
    .end_of_text_i (end_of_text_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .data_byte_o   (data_byte_o),
    .status_o      (status_o),
    .total_bytes_o (total_bytes_o),
    .last_of_run_o (last_of_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stimulus and result stores
  beat_t      char_beats [$];
  result_t    due_results [$];
  logic [7:0] text_chars [$];
  bit         drain_next = 1'b0;
  bit         drain_set = 1'b0;

  // Decoder state as predicted
  logic [7:0] grp_chars [0:2] = '{8'h00, 8'h00, 8'h00};
  int         grp_len = 0;
  status_e    text_err = StOk;
  int         text_bytes = 0;
  result_t    run_buf [0:3];
  int         run_len = 0;

  // Bookkeeping
  int     n_beats_queued = 0;
  int     n_rand_beats = 0;
  int     n_texts = 0;
  int     n_accepted = 0;
  int     n_checked = 0;
  int     n_mismatch = 0;
  int     n_full_hits = 0;
  longint n_cycles = 0;
  longint cycle_limit = 0;

  // Six-bit value of a Base64 character, -1 when it is not one
  function automatic int sextet_val(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return c - 8'h41;
    if (c >= 8'h61 && c <= 8'h7A) return c - 8'h61 + 26;
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30 + 52;
    if (c == PlusCode) return 62;
    if (c == SlashCode) return 63;
    return -1;
  endfunction

  function automatic void add_result(input logic kind, input logic [7:0] data,
                                     input status_e st, input logic [15:0] total);
    result_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = st;
    r.total  = total;
    r.last   = 1'b0;
    run_buf[run_len] = r;
    run_len++;
  endfunction

  // Strip trailing pads, validate, and emit n-1 bytes; grp[0] is the oldest
  function automatic void close_group(input logic [3:0][7:0] grp, input int len);
    int n;
    int v;
    logic [3:0][5:0] sx;
    logic [23:0] word;
    n = len;
    sx = '0;
    while (n > 0 && grp[n-1] == PadCode) n--;
    if (n < 2) begin
      text_err = StShort;
      return;
    end
    for (int i = 0; i < n; i++) begin
      v = sextet_val(grp[i]);
      if (v < 0) begin
        text_err = StInvalid;
        return;
      end
      sx[i] = v[5:0];
    end
    word = {sx[0], sx[1], sx[2], sx[3]};
    for (int i = 0; i < n - 1; i++) add_result(1'b0, word[23-8*i -: 8], StOk, 16'h0000);
    text_bytes = text_bytes + n - 1;
    if (text_bytes > 65535) text_bytes = 65535;
  endfunction

  // Work out the results caused by one accepted beat
  function automatic void decode_beat(input beat_t b);
    result_t r;
    run_len = 0;
    if (b.has && text_err == StOk) begin
      if (grp_len == GroupSize - 1) begin
        grp_len = 0;
        close_group({b.code, grp_chars[2], grp_chars[1], grp_chars[0]}, GroupSize);
      end else begin
        grp_chars[grp_len] = b.code;
        grp_len++;
      end
    end
    if (b.eot) begin
      if (text_err == StOk && grp_len > 0)
        close_group({8'h00, grp_chars[2], grp_chars[1], grp_chars[0]}, grp_len);
      add_result(1'b1, 8'h00, text_err, text_bytes[15:0]);
      grp_len = 0;
      text_err = StOk;
      text_bytes = 0;
    end
    if (run_len > 0) begin
      r = run_buf[run_len-1];
      r.last = 1'b1;
      run_buf[run_len-1] = r;
    end
    for (int i = 0; i < run_len; i++) due_results.push_back(run_buf[i]);
  endfunction

  // Stimulus helpers
  task automatic add_beat(input logic [7:0] code, input logic has, input logic eot);
    beat_t b;
    b.code  = code;
    b.has   = has;
    b.eot   = eot;
    b.drain = drain_next;
    drain_next = 1'b0;
    char_beats.push_back(b);
    n_beats_queued++;
    if (has || eot) n_rand_beats++;
    if (eot) n_texts++;
  endtask

  task automatic add_text(input string s, input int end_mode);
    for (int i = 0; i < s.len(); i++)
      add_beat(s[i], 1'b1, (end_mode == EndOnLast) && (i == s.len() - 1));
    if (end_mode == EndBare) add_beat(8'h00, 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] rand_b64();
    int idx;
    idx = $urandom_range(0, 63);
    if (idx < 26) return 8'(8'h41 + idx);
    if (idx < 52) return 8'(8'h61 + idx - 26);
    if (idx < 62) return 8'(8'h30 + idx - 52);
    if (idx == 62) return PlusCode;
    return SlashCode;
  endfunction

  function automatic logic [7:0] rand_bad();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (sextet_val(c) >= 0 || c == PadCode) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // One random text: mostly well formed, some broken, some pure noise
  task automatic gen_text();
    int sel;
    int groups;
    int len;
    int pos;
    bit end_on_char;
    text_chars.delete();
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      len = $urandom_range(1, 9);
      repeat (len) text_chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      groups = $urandom_range(0, 3);
      repeat (4 * groups) text_chars.push_back(rand_b64());
      case ($urandom_range(0, 4))
        1: repeat (2) text_chars.push_back(rand_b64());
        2: repeat (3) text_chars.push_back(rand_b64());
        3: begin
          repeat (2) text_chars.push_back(rand_b64());
          repeat (2) text_chars.push_back(PadCode);
        end
        4: begin
          repeat (3) text_chars.push_back(rand_b64());
          text_chars.push_back(PadCode);
        end
        default: ;
      endcase
      if (sel < 40) begin
        case ($urandom_range(0, 3))
          0: begin
            if (text_chars.size() == 0) text_chars.push_back(rand_bad());
            else text_chars[$urandom_range(0, text_chars.size() - 1)] = rand_bad();
          end
          1: begin
            if (text_chars.size() == 0) text_chars.push_back(PadCode);
            pos = $urandom_range(0, text_chars.size() - 1);
            text_chars[pos] = PadCode;
          end
          2: begin
            while (text_chars.size() % 4 != 0) void'(text_chars.pop_back());
            text_chars.push_back(rand_b64());
          end
          default: begin
            while (text_chars.size() % 4 != 0) void'(text_chars.pop_back());
            repeat (4) text_chars.push_back(PadCode);
          end
        endcase
      end
    end
    end_on_char = (text_chars.size() > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < text_chars.size(); i++) begin
      if ($urandom_range(0, 11) == 0) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_beat(text_chars[i], 1'b1, end_on_char && (i == text_chars.size() - 1));
    end
    if (!end_on_char) add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Driver: bursts of beats with random gaps; a marked beat waits for the output to drain
  beat_t cur_beat = '0;
  beat_t next_beat;
  bit    offering = 1'b0;
  int    gap_left = 0;
  int    burst_left = 1;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && full) n_full_hits++;
      if (push && !full) begin
        decode_beat(cur_beat);
        n_accepted++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (char_beats.size() > 0) begin
          next_beat = char_beats[0];
          if (!(next_beat.drain && due_results.size() > 0)) begin
            cur_beat = char_beats.pop_front();
            offering = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                         $urandom_range(1, 16);
              gap_left = $urandom_range(0, GAP_MAX);
            end
          end
        end
      end
      push          <= offering;
      char_code_i   <= cur_beat.code;
      has_char_i    <= cur_beat.has;
      end_of_text_i <= cur_beat.eot;
    end
  end

  // Compare one accepted result beat with the oldest prediction
  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      if (n_mismatch < 10)
        $display("[%0t] unexpected result: kind %0d data %02h status %0d total %0d last %0d",
                 $realtime, kind_o, data_byte_o, status_o, total_bytes_o, last_of_run_o);
      n_mismatch++;
    end else begin
      want = due_results.pop_front();
      n_checked++;
      if (kind_o !== want.kind || data_byte_o !== want.data || status_o !== want.status ||
          total_bytes_o !== want.total || last_of_run_o !== want.last) begin
        if (n_mismatch < 10) begin
          $write("[%0t] result %0d mismatch: kind %0d/%0d data %02h/%02h ",
                 $realtime, n_checked, want.kind, kind_o, want.data, data_byte_o);
          $display("status %0d/%0d total %0d/%0d last %0d/%0d (expected/actual)",
                   want.status, status_o, want.total, total_bytes_o, want.last,
                   last_of_run_o);
        end
        n_mismatch++;
      end
    end
  endtask

  // Monitor and receiver: stall pattern in changing modes plus one long hold-off
  rx_mode_e rx_mode = RxFree;
  int       mode_left = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  logic     pop_next;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result();
      if (hold_left > 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else if (!hold_done && n_checked >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        pop_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 60);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RxFree:  pop_next = 1'b1;
          RxCoin:  pop_next = 1'($urandom_range(0, 1));
          default: pop_next = ($urandom_range(0, 3) == 0);
        endcase
      end
      pop <= pop_next;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // Directed: padding, bare items, misplaced pad, code zero, error mid-text,
    // characters after an error, empty text, too-short group
    add_text("/+9=", EndOnLast);
    add_beat("z", 1'b1, 1'b0);
    add_beat("z", 1'b1, 1'b0);
    add_beat(8'h00, 1'b0, 1'b0);
    add_beat(8'h00, 1'b0, 1'b1);
    add_text("A=B=", EndOnLast);
    add_text("QUJD", EndNone);
    add_beat("z", 1'b1, 1'b0);
    add_beat(8'h00, 1'b1, 1'b0);
    add_text("zz", EndNone);
    add_beat(8'hFF, 1'b1, 1'b1);
    add_beat(8'hFF, 1'b0, 1'b1);
    add_text("A", EndOnLast);

    // Random texts; one drain point half way
    n_rand_beats = 0;
    while (n_rand_beats < RAND_BEATS) begin
      if (!drain_set && n_rand_beats >= RAND_BEATS / 2) begin
        drain_next = 1'b1;
        drain_set  = 1'b1;
      end
      gen_text();
    end

    cycle_limit = 4 * (longint'(n_beats_queued) * (GAP_MAX + 2) +
                       4 * longint'(n_beats_queued) * 10) + HOLD_LEN + 10000;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_beats.size() > 0 || offering || due_results.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run: %0d beats in %0d texts, %0d results checked.",
             n_accepted, n_texts, n_checked);
    $display("Input held off by full on %0d cycles; %0d mismatches or stray results.",
             n_full_hits, n_mismatch);
    if (n_mismatch == 0 && due_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    @(posedge rst_ni);
    while (n_cycles < cycle_limit) begin
      @(posedge clk_i);
      n_cycles++;
    end
    $display("Timeout after %0d cycles, %0d results still due.", n_cycles,
             due_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
